>>> rtl/assert_macros.svh
// Assertion macros shared by the RTL.
// Define NO_ASSERTIONS to compile them out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// Same-cycle implication, checked out of reset
`define ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("implication check failed");
// Next-cycle implication, checked out of reset
`define ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("next-cycle check failed");
`else
`define ASSERT_IMP(label, clk, rst_n, ante, cons)
`define ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

>>> rtl/rtp_pkg.sv
package rtp_pkg;

	// Result field widths
	localparam int EPOCH_W = 39;
	localparam int NS_W    = 30;

	// ASCII characters the parser looks for
	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_DASH  = 8'h2D;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_COLON = 8'h3A;
	localparam logic [7:0] CH_DOT   = 8'h2E;
	localparam logic [7:0] CH_T     = 8'h54;
	localparam logic [7:0] CH_Z     = 8'h5A;

	// Shortest string that can hold a full timestamp with zone
	localparam logic [4:0] MIN_LEN = 5'd20;

	// Day count shift: 0000-03-01 era offset plus one era of bias
	localparam logic [22:0] DAYS_BIAS = 23'd865565;

	// floor(x / 100) as (x * RECIP_100) >> RECIP_SHIFT, exact for x < 10400
	localparam logic [12:0] RECIP_100   = 13'd5243;
	localparam int          RECIP_SHIFT = 19;

	// Parse phase, one-hot
	typedef enum logic [8:0] {
		PH_DATE      = 9'b000000001,
		PH_AFTER_SEC = 9'b000000010,
		PH_FRAC      = 9'b000000100,
		PH_TZ_H1     = 9'b000001000,
		PH_TZ_H2     = 9'b000010000,
		PH_TZ_COLON  = 9'b000100000,
		PH_TZ_M1     = 9'b001000000,
		PH_TZ_M2     = 9'b010000000,
		PH_DONE      = 9'b100000000
	} phase_t;

	// Commands from controller to datapath
	typedef struct packed {
		logic take_byte;
		logic adv_s1;
		logic adv_s2;
		logic adv_s3;
		logic adv_s4;
		logic load_out;
	} cmd_t;

	// Days before the first of a month, counted from March
	function automatic logic [8:0] month_offset(input logic [3:0] month);
		logic [8:0] off;
		case (month)
			4'd1:    off = 9'd306;
			4'd2:    off = 9'd337;
			4'd3:    off = 9'd0;
			4'd4:    off = 9'd31;
			4'd5:    off = 9'd61;
			4'd6:    off = 9'd92;
			4'd7:    off = 9'd122;
			4'd8:    off = 9'd153;
			4'd9:    off = 9'd184;
			4'd10:   off = 9'd214;
			4'd11:   off = 9'd245;
			4'd12:   off = 9'd275;
			default: off = 9'd0;
		endcase
		return off;
	endfunction

	// Powers of ten for the fraction scale
	function automatic logic [29:0] pow10(input logic [3:0] n);
		logic [29:0] p;
		case (n)
			4'd0:    p = 30'd1;
			4'd1:    p = 30'd10;
			4'd2:    p = 30'd100;
			4'd3:    p = 30'd1000;
			4'd4:    p = 30'd10000;
			4'd5:    p = 30'd100000;
			4'd6:    p = 30'd1000000;
			4'd7:    p = 30'd10000000;
			4'd8:    p = 30'd100000000;
			4'd9:    p = 30'd1000000000;
			default: p = 30'd1;
		endcase
		return p;
	endfunction

endpackage

>>> rtl/rtp_ctrl.sv
module rtp_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	input  logic           in_last,
	output logic           in_ready,
	output logic           out_valid,
	input  logic           out_ready,
	output rtp_pkg::cmd_t  cmd
);

	typedef enum logic [5:0] {
		ST_PARSE = 6'b000001,
		ST_CV1   = 6'b000010,
		ST_CV2   = 6'b000100,
		ST_CV3   = 6'b001000,
		ST_CV4   = 6'b010000,
		ST_CV5   = 6'b100000
	} state_t;

	state_t state_q, state_n;
	logic   out_valid_q;
	logic   out_free;

	assign out_free  = !out_valid_q || out_ready;
	assign in_ready  = (state_q == ST_PARSE);
	assign out_valid = out_valid_q;

	// Sequence: take bytes, then walk the conversion stages
	always_comb begin
		state_n = state_q;
		cmd     = '0;
		case (state_q)
			ST_PARSE: begin
				cmd.take_byte = in_valid;
				if (in_valid && in_last) begin
					state_n = ST_CV1;
				end
			end
			ST_CV1: begin
				cmd.adv_s1 = 1'b1;
				state_n    = ST_CV2;
			end
			ST_CV2: begin
				cmd.adv_s2 = 1'b1;
				state_n    = ST_CV3;
			end
			ST_CV3: begin
				cmd.adv_s3 = 1'b1;
				state_n    = ST_CV4;
			end
			ST_CV4: begin
				cmd.adv_s4 = 1'b1;
				state_n    = ST_CV5;
			end
			ST_CV5: begin
				// hold until the output register is free
				if (out_free) begin
					cmd.load_out = 1'b1;
					state_n      = ST_PARSE;
				end
			end
			default: begin
				state_n = ST_PARSE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_PARSE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_n;
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

>>> rtl/rtp_datapath.sv
module rtp_datapath (
	input  logic                           clk,
	input  logic                           arst_n,
	input  rtp_pkg::cmd_t                  cmd,
	input  logic [7:0]                     in_byte,
	output logic                           res_status,
	output logic [rtp_pkg::EPOCH_W-1:0]    res_epoch,
	output logic [rtp_pkg::NS_W-1:0]       res_ns
);

	// Parse state
	logic [4:0]       pos_q, pos_n;
	rtp_pkg::phase_t  phase_q, phase_n;
	logic [13:0]      year_q, year_n;
	logic [6:0]       month_q, month_n;
	logic [6:0]       day_q, day_n;
	logic [6:0]       hour_q, hour_n;
	logic [6:0]       minute_q, minute_n;
	logic [6:0]       second_q, second_n;
	logic [29:0]      frac_q, frac_n;
	logic [3:0]       frac_cnt_q, frac_cnt_n;
	logic             zneg_q, zneg_n;
	logic [6:0]       zhour_q, zhour_n;
	logic [6:0]       zmin_q, zmin_n;
	logic             err_q, err_n;
	logic             ended_q, ended_n;

	logic             is_dig;
	logic [7:0]       dig_diff;
	logic [3:0]       dig;
	logic             zstart_ok;
	rtp_pkg::phase_t  zstart_phase;

	// Conversion stages
	logic             ok_s1, ok_s2, ok_s3, ok_s4;
	logic [14:0]      yy_s1, yy_s2;
	logic [8:0]       doy_s1, doy_s2;
	logic [16:0]      tod_s1, tod_s2, tod_s3;
	logic [18:0]      off_s1, off_s2, off_s3;
	logic             zneg_s1, zneg_s2, zneg_s3;
	logic [29:0]      frac_s1, scale_s1;
	logic [29:0]      ns_s2, ns_s3, ns_s4;
	logic [22:0]      p365_s2;
	logic [6:0]       q100_s2;
	logic [22:0]      days_s3;
	logic [38:0]      dsec_s4;
	logic [19:0]      part_s4;

	logic             ok_now;
	logic [27:0]      q100_prod;
	logic [59:0]      ns_prod;
	logic signed [39:0] dsec_prod;
	logic [38:0]      epoch_sum;

	// Output register
	logic                        status_q;
	logic [rtp_pkg::EPOCH_W-1:0] epoch_q;
	logic [rtp_pkg::NS_W-1:0]    ns_q;

	// Classify the byte
	assign dig_diff = in_byte - rtp_pkg::CH_ZERO;
	assign dig      = dig_diff[3:0];
	assign is_dig   = (in_byte >= rtp_pkg::CH_ZERO) && (in_byte <= rtp_pkg::CH_NINE);
	assign zstart_ok = (in_byte == rtp_pkg::CH_Z) || (in_byte == rtp_pkg::CH_PLUS) ||
		(in_byte == rtp_pkg::CH_DASH);
	assign zstart_phase = (in_byte == rtp_pkg::CH_Z) ? rtp_pkg::PH_DONE : rtp_pkg::PH_TZ_H1;

	// Next parse state for one byte
	always_comb begin
		pos_n      = pos_q;
		phase_n    = phase_q;
		year_n     = year_q;
		month_n    = month_q;
		day_n      = day_q;
		hour_n     = hour_q;
		minute_n   = minute_q;
		second_n   = second_q;
		frac_n     = frac_q;
		frac_cnt_n = frac_cnt_q;
		zneg_n     = zneg_q;
		zhour_n    = zhour_q;
		zmin_n     = zmin_q;
		err_n      = err_q;
		ended_n    = ended_q;
		if (cmd.adv_s1) begin
			// drop the finished string
			pos_n      = '0;
			phase_n    = rtp_pkg::PH_DATE;
			year_n     = '0;
			month_n    = '0;
			day_n      = '0;
			hour_n     = '0;
			minute_n   = '0;
			second_n   = '0;
			frac_n     = '0;
			frac_cnt_n = '0;
			zneg_n     = 1'b0;
			zhour_n    = '0;
			zmin_n     = '0;
			err_n      = 1'b0;
			ended_n    = 1'b0;
		end else if (cmd.take_byte && !ended_q) begin
			if (in_byte == rtp_pkg::CH_NUL) begin
				ended_n = 1'b1;
			end else begin
				if (!err_q) begin
					case (phase_q)
						rtp_pkg::PH_DATE: begin
							if (pos_q == 5'd4 || pos_q == 5'd7) begin
								if (in_byte != rtp_pkg::CH_DASH) err_n = 1'b1;
							end else if (pos_q == 5'd10) begin
								if (in_byte != rtp_pkg::CH_T) err_n = 1'b1;
							end else if (pos_q == 5'd13 || pos_q == 5'd16) begin
								if (in_byte != rtp_pkg::CH_COLON) err_n = 1'b1;
							end else if (!is_dig) begin
								err_n = 1'b1;
							end else if (pos_q <= 5'd3) begin
								year_n = year_q * 14'd10 + {10'd0, dig};
							end else if (pos_q <= 5'd6) begin
								month_n = month_q * 7'd10 + {3'd0, dig};
							end else if (pos_q <= 5'd9) begin
								day_n = day_q * 7'd10 + {3'd0, dig};
							end else if (pos_q <= 5'd12) begin
								hour_n = hour_q * 7'd10 + {3'd0, dig};
							end else if (pos_q <= 5'd15) begin
								minute_n = minute_q * 7'd10 + {3'd0, dig};
							end else begin
								second_n = second_q * 7'd10 + {3'd0, dig};
							end
							if (pos_q >= 5'd18) phase_n = rtp_pkg::PH_AFTER_SEC;
						end
						rtp_pkg::PH_AFTER_SEC: begin
							if (in_byte == rtp_pkg::CH_DOT) begin
								phase_n = rtp_pkg::PH_FRAC;
							end else if (zstart_ok) begin
								phase_n = zstart_phase;
								if (in_byte != rtp_pkg::CH_Z) begin
									zneg_n = (in_byte == rtp_pkg::CH_DASH);
								end
							end else begin
								err_n = 1'b1;
							end
						end
						rtp_pkg::PH_FRAC: begin
							if (is_dig) begin
								// skip digits beyond nanoseconds
								if (frac_cnt_q < 4'd9) begin
									frac_n     = frac_q * 30'd10 + {26'd0, dig};
									frac_cnt_n = frac_cnt_q + 4'd1;
								end
							end else if (zstart_ok) begin
								phase_n = zstart_phase;
								if (in_byte != rtp_pkg::CH_Z) begin
									zneg_n = (in_byte == rtp_pkg::CH_DASH);
								end
							end else begin
								err_n = 1'b1;
							end
						end
						rtp_pkg::PH_TZ_H1: begin
							if (is_dig) begin
								zhour_n = {3'd0, dig};
								phase_n = rtp_pkg::PH_TZ_H2;
							end else begin
								err_n = 1'b1;
							end
						end
						rtp_pkg::PH_TZ_H2: begin
							if (is_dig) begin
								zhour_n = zhour_q * 7'd10 + {3'd0, dig};
								phase_n = rtp_pkg::PH_TZ_COLON;
							end else begin
								err_n = 1'b1;
							end
						end
						rtp_pkg::PH_TZ_COLON: begin
							phase_n = (in_byte == rtp_pkg::CH_COLON) ?
								rtp_pkg::PH_TZ_M1 : rtp_pkg::PH_DONE;
						end
						rtp_pkg::PH_TZ_M1: begin
							if (is_dig) begin
								zmin_n  = {3'd0, dig};
								phase_n = rtp_pkg::PH_TZ_M2;
							end else begin
								err_n = 1'b1;
							end
						end
						rtp_pkg::PH_TZ_M2: begin
							if (is_dig) begin
								zmin_n  = zmin_q * 7'd10 + {3'd0, dig};
								phase_n = rtp_pkg::PH_DONE;
							end else begin
								err_n = 1'b1;
							end
						end
						default: begin
						end
					endcase
				end
				// count bytes, saturating
				if (pos_q != 5'd31) pos_n = pos_q + 5'd1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q      <= '0;
			phase_q    <= rtp_pkg::PH_DATE;
			year_q     <= '0;
			month_q    <= '0;
			day_q      <= '0;
			hour_q     <= '0;
			minute_q   <= '0;
			second_q   <= '0;
			frac_q     <= '0;
			frac_cnt_q <= '0;
			zneg_q     <= 1'b0;
			zhour_q    <= '0;
			zmin_q     <= '0;
			err_q      <= 1'b0;
			ended_q    <= 1'b0;
		end else begin
			pos_q      <= pos_n;
			phase_q    <= phase_n;
			year_q     <= year_n;
			month_q    <= month_n;
			day_q      <= day_n;
			hour_q     <= hour_n;
			minute_q   <= minute_n;
			second_q   <= second_n;
			frac_q     <= frac_n;
			frac_cnt_q <= frac_cnt_n;
			zneg_q     <= zneg_n;
			zhour_q    <= zhour_n;
			zmin_q     <= zmin_n;
			err_q      <= err_n;
			ended_q    <= ended_n;
		end
	end

	// Final validity of the parsed string
	assign ok_now = !err_q &&
		(phase_q == rtp_pkg::PH_DONE || phase_q == rtp_pkg::PH_TZ_COLON) &&
		(pos_q >= rtp_pkg::MIN_LEN) &&
		(month_q >= 7'd1) && (month_q <= 7'd12) &&
		(day_q >= 7'd1) && (day_q <= 7'd31) &&
		(hour_q <= 7'd23) && (minute_q <= 7'd59) && (second_q <= 7'd60);

	// Stage 1: shifted year, day of year, time of day, zone offset, fraction scale
	always_ff @(posedge clk) begin
		if (cmd.adv_s1) begin
			ok_s1    <= ok_now;
			yy_s1    <= {1'b0, year_q} - ((month_q <= 7'd2) ? 15'd1 : 15'd0) + 15'd400;
			doy_s1   <= rtp_pkg::month_offset(month_q[3:0]) + {2'd0, day_q} - 9'd1;
			tod_s1   <= {10'd0, hour_q} * 17'd3600 + {10'd0, minute_q} * 17'd60 +
				{10'd0, second_q};
			off_s1   <= {12'd0, zhour_q} * 19'd3600 + {12'd0, zmin_q} * 19'd60;
			zneg_s1  <= zneg_q;
			frac_s1  <= frac_q;
			scale_s1 <= rtp_pkg::pow10(4'd9 - frac_cnt_q);
		end
	end

	// Stage 2: year products and fraction scaling
	assign q100_prod = {13'd0, yy_s1} * {15'd0, rtp_pkg::RECIP_100};
	assign ns_prod   = {30'd0, frac_s1} * {30'd0, scale_s1};

	always_ff @(posedge clk) begin
		if (cmd.adv_s2) begin
			ok_s2   <= ok_s1;
			p365_s2 <= {8'd0, yy_s1} * 23'd365;
			q100_s2 <= q100_prod[rtp_pkg::RECIP_SHIFT +: 7];
			ns_s2   <= ns_prod[29:0];
			yy_s2   <= yy_s1;
			doy_s2  <= doy_s1;
			tod_s2  <= tod_s1;
			off_s2  <= off_s1;
			zneg_s2 <= zneg_s1;
		end
	end

	// Stage 3: days from civil, two's complement
	always_ff @(posedge clk) begin
		if (cmd.adv_s3) begin
			ok_s3   <= ok_s2;
			days_s3 <= p365_s2 + {10'd0, yy_s2[14:2]} + {18'd0, q100_s2[6:2]} -
				{16'd0, q100_s2} + {14'd0, doy_s2} - rtp_pkg::DAYS_BIAS;
			ns_s3   <= ns_s2;
			tod_s3  <= tod_s2;
			off_s3  <= off_s2;
			zneg_s3 <= zneg_s2;
		end
	end

	// Stage 4: day seconds and zone-adjusted time of day
	assign dsec_prod = $signed(days_s3) * $signed(18'd86400);

	always_ff @(posedge clk) begin
		if (cmd.adv_s4) begin
			ok_s4   <= ok_s3;
			dsec_s4 <= dsec_prod[38:0];
			part_s4 <= zneg_s3 ? ({3'd0, tod_s3} + {1'b0, off_s3}) :
				({3'd0, tod_s3} - {1'b0, off_s3});
			ns_s4   <= ns_s3;
		end
	end

	// Output register: zero the fields on error
	assign epoch_sum = dsec_s4 + {{19{part_s4[19]}}, part_s4};

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			status_q <= !ok_s4;
			epoch_q  <= ok_s4 ? epoch_sum : '0;
			ns_q     <= ok_s4 ? ns_s4 : '0;
		end
	end

	assign res_status = status_q;
	assign res_epoch  = epoch_q;
	assign res_ns     = ns_q;

endmodule

>>> rtl/rfc3339_timestamp_parser.sv
// Takes one byte per cycle while parsing; the last byte of a string starts a
// conversion (four stages plus the output load, which waits for a free output
// register) during which input is held off.
// The result register frees the input side: the next string streams in while
// a result waits. arst_n clears the parse state, sequencer and output valid.
`include "assert_macros.svh"

module rfc3339_timestamp_parser (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // [7:0] char_byte
	input  logic        s_axis_tlast,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [71:0] m_axis_tdata,   // [38:0] epoch_seconds, [68:39] nanoseconds
	output logic        m_axis_tuser    // [0] status
);

	rtp_pkg::cmd_t               cmd;
	logic                        res_status;
	logic [rtp_pkg::EPOCH_W-1:0] res_epoch;
	logic [rtp_pkg::NS_W-1:0]    res_ns;

	rtp_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_last   (s_axis_tlast),
		.in_ready  (s_axis_tready),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.cmd       (cmd)
	);

	rtp_datapath u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.in_byte    (s_axis_tdata),
		.res_status (res_status),
		.res_epoch  (res_epoch),
		.res_ns     (res_ns)
	);

	// Pack the result transaction
	assign m_axis_tdata = {3'd0, res_ns, res_epoch};
	assign m_axis_tuser = res_status;

	// The last byte of a string always starts the conversion
	`ASSERT_NXT(a_last_starts_conv, clk, arst_n, s_axis_tvalid && s_axis_tready && s_axis_tlast, !s_axis_tready)
	// A failed parse carries zero fields
	`ASSERT_IMP(a_error_zeroed, clk, arst_n, m_axis_tvalid && m_axis_tuser, m_axis_tdata == 72'd0)
	// Nanoseconds stay below one second
	`ASSERT_IMP(a_ns_range, clk, arst_n, m_axis_tvalid && !m_axis_tuser, m_axis_tdata[68:39] < 30'd1000000000)

endmodule

>>> sim/tb_rfc3339_timestamp_parser.sv
`timescale 1ns / 1ps

module tb_rfc3339_timestamp_parser;
	import rtp_pkg::*;

	localparam int RANDOM_BYTES   = 1100;
	localparam int WATCHDOG_LIMIT = 4000;
	localparam int DRAIN_CYCLES   = 20;
	localparam int MAX_REPORTS    = 10;
	// '#' in a directed row stands for a zero byte
	localparam logic [7:0] NUL_MARK = 8'h23;

	typedef struct packed {
		logic              status;
		logic [EPOCH_W-1:0] epoch;
		logic [NS_W-1:0]    nanos;
	} stamp_result_t;

	typedef struct {
		string         text;
		bit            typed;
		stamp_result_t want;
	} stamp_row_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [7:0]  s_axis_tdata = 8'h00;   // [7:0] char_byte
	logic        s_axis_tlast = 1'b0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [71:0] m_axis_tdata;           // [38:0] epoch_seconds, [68:39] nanoseconds
	logic        m_axis_tuser;           // [0] status

	rfc3339_timestamp_parser dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Predicted results waiting for their output transaction
	stamp_result_t stamps_due[$];
	stamp_row_t    directed_rows[$];
	logic [7:0]    line_q[$];

	int strings_sent = 0;
	int bytes_sent = 0;
	int results_seen = 0;
	int results_ok = 0;
	int mismatches = 0;
	int burst_left = 0;
	int idle_cycles = 0;

	// Parser state as the predictor tracks it
	phase_t      phase;
	logic [4:0]  at_char;
	logic [13:0] year_v;
	logic [6:0]  month_v, day_v, hour_v, min_v, sec_v;
	logic [29:0] frac_v;
	logic [3:0]  frac_cnt;
	logic        zone_west;
	logic [6:0]  zone_h, zone_m;
	logic        bad_char, nul_seen;

	function automatic bit is_digit(input logic [7:0] b);
		return b >= CH_ZERO && b <= CH_NINE;
	endfunction

	function automatic longint days_from_civil(input longint y, input longint m,
			input longint d);
		longint yy, era, yoe, mp, doy, doe;
		yy  = y - ((m <= 2) ? 1 : 0) + 400;
		era = yy / 400;
		yoe = yy - era * 400;
		mp  = (m + 9) % 12;
		doy = (153 * mp + 2) / 5 + d - 1;
		doe = yoe * 365 + yoe / 4 - yoe / 100 + doy;
		return era * 146097 + doe - 719468 - 146097;
	endfunction

	task automatic clear_parse();
		phase = PH_DATE;
		at_char = '0;
		year_v = '0;
		month_v = '0;
		day_v = '0;
		hour_v = '0;
		min_v = '0;
		sec_v = '0;
		frac_v = '0;
		frac_cnt = '0;
		zone_west = 1'b0;
		zone_h = '0;
		zone_m = '0;
		bad_char = 1'b0;
		nul_seen = 1'b0;
	endtask

	task automatic open_zone(input logic [7:0] b);
		if (b == CH_Z) begin
			phase = PH_DONE;
		end else if (b == CH_PLUS || b == CH_DASH) begin
			zone_west = (b == CH_DASH);
			phase = PH_TZ_H1;
		end else begin
			bad_char = 1'b1;
		end
	endtask

	task automatic parse_char(input logic [7:0] b);
		logic [3:0] d;
		d = 4'(b - CH_ZERO);
		case (phase)
			PH_DATE: begin
				if (at_char == 5'd4 || at_char == 5'd7) begin
					if (b != CH_DASH) bad_char = 1'b1;
				end else if (at_char == 5'd10) begin
					if (b != CH_T) bad_char = 1'b1;
				end else if (at_char == 5'd13 || at_char == 5'd16) begin
					if (b != CH_COLON) bad_char = 1'b1;
				end else if (!is_digit(b)) begin
					bad_char = 1'b1;
				end else if (at_char <= 5'd3) begin
					year_v = year_v * 14'd10 + {10'd0, d};
				end else if (at_char <= 5'd6) begin
					month_v = month_v * 7'd10 + {3'd0, d};
				end else if (at_char <= 5'd9) begin
					day_v = day_v * 7'd10 + {3'd0, d};
				end else if (at_char <= 5'd12) begin
					hour_v = hour_v * 7'd10 + {3'd0, d};
				end else if (at_char <= 5'd15) begin
					min_v = min_v * 7'd10 + {3'd0, d};
				end else begin
					sec_v = sec_v * 7'd10 + {3'd0, d};
				end
				if (at_char >= 5'd18) phase = PH_AFTER_SEC;
			end
			PH_AFTER_SEC: begin
				if (b == CH_DOT) phase = PH_FRAC;
				else open_zone(b);
			end
			PH_FRAC: begin
				if (is_digit(b)) begin
					// keep nine digits, skip the rest
					if (frac_cnt < 4'd9) begin
						frac_v = frac_v * 30'd10 + {26'd0, d};
						frac_cnt++;
					end
				end else begin
					open_zone(b);
				end
			end
			PH_TZ_H1: begin
				if (is_digit(b)) begin
					zone_h = {3'd0, d};
					phase = PH_TZ_H2;
				end else begin
					bad_char = 1'b1;
				end
			end
			PH_TZ_H2: begin
				if (is_digit(b)) begin
					zone_h = zone_h * 7'd10 + {3'd0, d};
					phase = PH_TZ_COLON;
				end else begin
					bad_char = 1'b1;
				end
			end
			PH_TZ_COLON: begin
				phase = (b == CH_COLON) ? PH_TZ_M1 : PH_DONE;
			end
			PH_TZ_M1: begin
				if (is_digit(b)) begin
					zone_m = {3'd0, d};
					phase = PH_TZ_M2;
				end else begin
					bad_char = 1'b1;
				end
			end
			PH_TZ_M2: begin
				if (is_digit(b)) begin
					zone_m = zone_m * 7'd10 + {3'd0, d};
					phase = PH_DONE;
				end else begin
					bad_char = 1'b1;
				end
			end
			default: ;
		endcase
	endtask

	// Advance the predicted parser by one accepted byte; on the last byte
	// queue the expected result and start a fresh string
	task automatic predict_char(input logic [7:0] b, input logic last);
		stamp_result_t r;
		longint secs, zoff, ns, h, mi, s;
		bit good;
		int k;
		if (!nul_seen) begin
			if (b == CH_NUL) begin
				nul_seen = 1'b1;
			end else begin
				if (!bad_char) parse_char(b);
				if (at_char != 5'd31) at_char++;
			end
		end
		if (last) begin
			good = !bad_char && (phase == PH_DONE || phase == PH_TZ_COLON)
				&& at_char >= MIN_LEN
				&& month_v >= 7'd1 && month_v <= 7'd12
				&& day_v >= 7'd1 && day_v <= 7'd31
				&& hour_v <= 7'd23 && min_v <= 7'd59 && sec_v <= 7'd60;
			r = '0;
			r.status = !good;
			if (good) begin
				h  = hour_v;
				mi = min_v;
				s  = sec_v;
				secs = days_from_civil(year_v, month_v, day_v) * 86400
					+ h * 3600 + mi * 60 + s;
				h  = zone_h;
				mi = zone_m;
				zoff = h * 3600 + mi * 60;
				secs = zone_west ? secs + zoff : secs - zoff;
				ns = frac_v;
				for (k = frac_cnt; k < 9; k++) ns = ns * 10;
				r.epoch = secs[EPOCH_W-1:0];
				r.nanos = ns[NS_W-1:0];
			end
			stamps_due.push_back(r);
			clear_parse();
		end
	endtask

	// Send one byte in bursts with random gaps; long bursts give stretches
	// with no idling at all
	task automatic send_byte(input logic [7:0] b, input logic last);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
			if (gap != 0) begin
				s_axis_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
				: $urandom_range(1, 16);
		end
		burst_left--;
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= b;
		s_axis_tlast <= last;
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		predict_char(b, last);
		bytes_sent++;
	endtask

	task automatic send_line();
		int i;
		for (i = 0; i < line_q.size(); i++) send_byte(line_q[i], i == line_q.size() - 1);
		strings_sent++;
	endtask

	// Hold off the input until every expected result has come out
	task automatic wait_drained();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (stamps_due.size() != 0) @(posedge clk);
	endtask

	task automatic add_row(input string text, input bit typed, input logic st,
			input longint ep, input longint ns);
		stamp_row_t row;
		row.text = text;
		row.typed = typed;
		row.want.status = st;
		row.want.epoch = ep[EPOCH_W-1:0];
		row.want.nanos = ns[NS_W-1:0];
		directed_rows.push_back(row);
	endtask

	task automatic push_num(input int value, input int ndigits);
		int div;
		logic [7:0] c;
		div = 1;
		repeat (ndigits - 1) div *= 10;
		repeat (ndigits) begin
			c = CH_ZERO + 8'((value / div) % 10);
			line_q.push_back(c);
			div /= 10;
		end
	endtask

	task automatic push_field(input int lo, input int hi, input int wild_hi);
		push_num(($urandom_range(0, 19) == 0) ? $urandom_range(0, wild_hi)
			: $urandom_range(lo, hi), 2);
	endtask

	// Build a timestamp with random content, mostly well formed; some lines
	// are pure noise, some get a corrupted byte or an early zero byte
	task automatic build_line();
		int n, idx, pick;
		logic [7:0] c;
		line_q = {};
		if ($urandom_range(0, 9) == 0) begin
			n = $urandom_range(1, 30);
			repeat (n) begin
				c = 8'($urandom_range(0, 255));
				line_q.push_back(c);
			end
		end else begin
			push_num($urandom_range(0, 9999), 4);
			line_q.push_back(CH_DASH);
			push_field(1, 12, 99);
			line_q.push_back(CH_DASH);
			push_field(1, 31, 99);
			line_q.push_back(CH_T);
			push_field(0, 23, 99);
			line_q.push_back(CH_COLON);
			push_field(0, 59, 99);
			line_q.push_back(CH_COLON);
			push_field(0, 60, 99);
			if ($urandom_range(0, 1) == 0) begin
				line_q.push_back(CH_DOT);
				n = $urandom_range(0, 12);
				repeat (n) push_num($urandom_range(0, 9), 1);
			end
			pick = $urandom_range(0, 9);
			if (pick <= 3) begin
				line_q.push_back(CH_Z);
			end else begin
				line_q.push_back($urandom_range(0, 1) ? CH_PLUS : CH_DASH);
				if (pick == 9) begin
					// broken zone: one hour digit, or a cut-off minute part
					push_num($urandom_range(0, 9), 1);
					if ($urandom_range(0, 1)) begin
						push_num($urandom_range(0, 9), 1);
						line_q.push_back(CH_COLON);
						if ($urandom_range(0, 1)) push_num($urandom_range(0, 9), 1);
					end
				end else begin
					push_num($urandom_range(0, 99), 2);
					if ($urandom_range(0, 9) < 7) begin
						line_q.push_back(CH_COLON);
						push_num($urandom_range(0, 99), 2);
					end
				end
			end
			if ($urandom_range(0, 4) == 0) begin
				n = $urandom_range(1, 5);
				repeat (n) begin
					c = 8'($urandom_range(1, 255));
					line_q.push_back(c);
				end
			end
			if ($urandom_range(0, 9) == 0) begin
				idx = $urandom_range(0, line_q.size() - 1);
				c = 8'($urandom_range(0, 255));
				line_q[idx] = c;
			end
			if ($urandom_range(0, 9) == 0) begin
				idx = $urandom_range(0, line_q.size() - 1);
				line_q.insert(idx, CH_NUL);
			end
		end
	endtask

	// Receiver stall pattern: switch between modes at random intervals
	int ready_mode = 0;
	int mode_left = 0;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
			ready_mode <= 0;
			mode_left <= 0;
		end else begin
			if (mode_left == 0) begin
				ready_mode <= $urandom_range(0, 3);
				mode_left <= $urandom_range(64, 256);
			end else begin
				mode_left <= mode_left - 1;
			end
			case (ready_mode)
				0: m_axis_tready <= 1'b1;
				1: m_axis_tready <= 1'($urandom_range(0, 1));
				2: m_axis_tready <= ($urandom_range(0, 7) == 0);
				default: m_axis_tready <= ~m_axis_tready;
			endcase
		end
	end

	// Compare each output transaction with the oldest prediction
	always @(posedge clk) begin
		stamp_result_t got, want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got.status = m_axis_tuser;
			got.epoch = m_axis_tdata[EPOCH_W-1:0];
			got.nanos = m_axis_tdata[EPOCH_W+NS_W-1:EPOCH_W];
			results_seen++;
			if (!got.status) results_ok++;
			if (stamps_due.size() == 0) begin
				mismatches++;
				if (mismatches <= MAX_REPORTS)
					$display("unexpected result: status %0d epoch %0d ns %0d",
						got.status, $signed(got.epoch), got.nanos);
			end else begin
				want = stamps_due.pop_front();
				if (got.status !== want.status || got.epoch !== want.epoch
						|| got.nanos !== want.nanos) begin
					mismatches++;
					if (mismatches <= MAX_REPORTS)
						$display("result %0d: expected status %0d epoch %0d ns %0d, got status %0d epoch %0d ns %0d",
							results_seen, want.status, $signed(want.epoch), want.nanos,
							got.status, $signed(got.epoch), got.nanos);
				end
			end
		end
	end

	// Watchdog: end the run when no transaction moves for too long
	always @(posedge clk) begin
		if (!arst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles == WATCHDOG_LIMIT) begin
			$display("timeout: no transaction for %0d cycles, %0d results pending",
				WATCHDOG_LIMIT, stamps_due.size());
			$display("== FAIL ==");
			$finish;
		end
	end

	initial begin
		int i, random_start;
		logic [7:0] c;
		clear_parse();

		add_row("1970-01-01T00:00:00Z", 1, 1'b0, 0, 0);
		add_row("0000-01-01T00:00:00+99:99", 1, 1'b0, -64'sd62167581540, 0);
		add_row("9999-12-31T23:59:60-99:99", 1, 1'b0, 64'sd253402663140, 0);
		add_row("1970-01-01T00:00:00.999999999Z", 1, 1'b0, 0, 999999999);
		add_row("2024-02-29T12:34:56.123456789012Z", 0, 1'b0, 0, 0);
		add_row("2001-02-31T00:00:00.5Z", 0, 1'b0, 0, 0);
		add_row("2016-12-31T23:59:60.Z", 0, 1'b0, 0, 0);
		add_row("2020-06-15T08:30:00+05", 0, 1'b0, 0, 0);
		add_row("2020-06-15T08:30:00-0530", 0, 1'b0, 0, 0);
		add_row("2020-06-15T08:30:00Ztrailing", 0, 1'b0, 0, 0);
		add_row("1970-01-01T00:00:00Z#junk", 1, 1'b0, 0, 0);
		add_row("1970-01-01T00:00:00", 1, 1'b1, 0, 0);
		add_row("1970-01#-01T00:00:00Z", 1, 1'b1, 0, 0);
		add_row("#", 1, 1'b1, 0, 0);
		add_row("1970-13-01T00:00:00Z", 1, 1'b1, 0, 0);
		add_row("1970-00-01T00:00:00Z", 1, 1'b1, 0, 0);
		add_row("1970-01-32T00:00:00Z", 1, 1'b1, 0, 0);
		add_row("1970-01-00T00:00:00Z", 1, 1'b1, 0, 0);
		add_row("1970-01-01T24:00:00Z", 1, 1'b1, 0, 0);
		add_row("1970-01-01T00:60:00Z", 1, 1'b1, 0, 0);
		add_row("1970-01-01T00:00:61Z", 1, 1'b1, 0, 0);
		add_row("1970/01-01T00:00:00Z", 1, 1'b1, 0, 0);
		add_row("1970-01-01T00:00:00+05:", 1, 1'b1, 0, 0);
		add_row("1970-01-01T00:00:00+05:3", 1, 1'b1, 0, 0);
		add_row("1970-01-01T00:00:00+5Z", 1, 1'b1, 0, 0);

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed rows; typed rows replace the predicted result
		foreach (directed_rows[r]) begin
			line_q = {};
			for (i = 0; i < directed_rows[r].text.len(); i++) begin
				c = directed_rows[r].text[i];
				line_q.push_back((c == NUL_MARK) ? CH_NUL : c);
			end
			send_line();
			if (directed_rows[r].typed) stamps_due[$] = directed_rows[r].want;
		end
		wait_drained();

		// Random strings
		random_start = bytes_sent;
		while (bytes_sent - random_start < RANDOM_BYTES) begin
			build_line();
			send_line();
			if ($urandom_range(0, 19) == 0) wait_drained();
		end
		s_axis_tvalid <= 1'b0;

		while (stamps_due.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("sent %0d strings in %0d bytes, %0d directed rows", strings_sent,
			bytes_sent, directed_rows.size());
		$display("checked %0d results: %0d parsed, %0d rejected, %0d mismatches",
			results_seen, results_ok, results_seen - results_ok, mismatches);
		if (mismatches == 0 && stamps_due.size() == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
